[rtl/core/lep_pkg.sv]
// Shared constants, command and status types for the Lyapunov exponent point core.
// Used by lep_ctrl, lep_dp and lyapunov_exponent_point_core; no dependencies.
`default_nettype none
package lep_pkg;

    localparam int ROUNDS      = 1000;
    localparam int MAX_PATTERN = 16;

    localparam logic [31:0] X_START = 32'd214748365;
    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
    localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;
    localparam logic [63:0] LOG_BIAS_64 =
        (((64'd60 << 24) * 64'hB172_17F8) + (64'd1 << 31)) >> 32;
    localparam logic [31:0] LOG_BIAS = LOG_BIAS_64[31:0];

    localparam int SQR_STEPS = 24;
    localparam int DIV_W     = $clog2(ROUNDS * MAX_PATTERN + 1);
    localparam int SUM_W     = 32 + $clog2(ROUNDS * MAX_PATTERN + 1);
    localparam int CNT_W     = $clog2(SUM_W);
    localparam int RND_W     = $clog2(ROUNDS + 1);

    localparam logic [2:0] CFG_A_LOW   = 3'd0;
    localparam logic [2:0] CFG_A_STEP  = 3'd1;
    localparam logic [2:0] CFG_B_LOW   = 3'd2;
    localparam logic [2:0] CFG_B_STEP  = 3'd3;
    localparam logic [2:0] CFG_C_LOW   = 3'd4;
    localparam logic [2:0] CFG_C_STEP  = 3'd5;
    localparam logic [2:0] CFG_PATTERN = 3'd6;
    localparam logic [2:0] CFG_LENGTH  = 3'd7;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_P,
        OP_X,
        OP_M,
        OP_NORM_HI,
        OP_NORM_LO,
        OP_SQR,
        OP_SCALE,
        OP_ACC,
        OP_DIV_INIT,
        OP_DIV,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] sel;
        logic [4:0] len;
    } t_cmd;

    typedef struct packed {
        logic m_zero;
    } t_stat;

endpackage
`default_nettype wire

[rtl/core/lep_ctrl.sv]
// Sequencer for the Lyapunov exponent point core: loop counters and datapath commands.
// Depends on lep_pkg.
`default_nettype none
module lep_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [31:0]     i_pattern,
    input  wire logic [4:0]      i_length,
    input  wire lep_pkg::t_stat  i_stat,
    output lep_pkg::t_cmd        o_cmd,
    output logic                 o_busy
);

    typedef enum logic [3:0] {
        S_IDLE, S_P, S_X, S_M, S_NHI, S_NLO, S_SQR, S_SCALE, S_ACC,
        S_DINIT, S_DIV, S_OUT
    } t_state;

    t_state                     r_state, n_state;
    logic [3:0]                 r_k, n_k;
    logic [lep_pkg::RND_W-1:0]  r_round, n_round;
    logic [lep_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [4:0]                 len;
    logic                       last_step;
    logic                       last_round;

    always_comb begin
        if (i_length == 5'd0) begin
            len = 5'd1;
        end else if (i_length > 5'(lep_pkg::MAX_PATTERN)) begin
            len = 5'(lep_pkg::MAX_PATTERN);
        end else begin
            len = i_length;
        end
        last_step  = ({1'b0, r_k} == (len - 5'd1));
        last_round = (r_round == lep_pkg::RND_W'(lep_pkg::ROUNDS - 1));

        o_cmd.op  = lep_pkg::OP_NONE;
        o_cmd.sel = i_pattern[{r_k, 1'b0} +: 2];
        o_cmd.len = len;
        n_state   = r_state;
        n_k       = r_k;
        n_round   = r_round;
        n_cnt     = r_cnt;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = lep_pkg::OP_LOAD;
                    n_k      = 4'd0;
                    n_round  = '0;
                    n_state  = S_P;
                end
            end
            S_P: begin
                o_cmd.op = lep_pkg::OP_P;
                n_state  = S_X;
            end
            S_X: begin
                o_cmd.op = lep_pkg::OP_X;
                n_state  = S_M;
            end
            S_M: begin
                o_cmd.op = lep_pkg::OP_M;
                n_state  = S_NHI;
            end
            S_NHI: begin
                o_cmd.op = lep_pkg::OP_NORM_HI;
                n_state  = S_NLO;
            end
            S_NLO: begin
                o_cmd.op = lep_pkg::OP_NORM_LO;
                n_cnt    = '0;
                n_state  = S_SQR;
            end
            S_SQR: begin
                o_cmd.op = lep_pkg::OP_SQR;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == lep_pkg::CNT_W'(lep_pkg::SQR_STEPS - 1)) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.op = lep_pkg::OP_SCALE;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.op = lep_pkg::OP_ACC;
            end
            S_DINIT: begin
                o_cmd.op = lep_pkg::OP_DIV_INIT;
                n_cnt    = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = lep_pkg::OP_DIV;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == lep_pkg::CNT_W'(lep_pkg::SUM_W - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.op = lep_pkg::OP_OUT;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A zero derivative skips the logarithm; either way the step ends here.
        if ((r_state == S_ACC) || ((r_state == S_NHI) && i_stat.m_zero)) begin
            if (last_step) begin
                n_k = 4'd0;
                if (last_round) begin
                    n_state = S_DINIT;
                end else begin
                    n_round = r_round + 1'b1;
                    n_state = S_P;
                end
            end else begin
                n_k     = r_k + 4'd1;
                n_state = S_P;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= 4'd0;
            r_round <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_round <= n_round;
            r_cnt   <= n_cnt;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

[rtl/core/lep_dp.sv]
// Datapath of the Lyapunov exponent point core: rates, map, log unit, sum and divider.
// Depends on lep_pkg; driven by commands from lep_ctrl.
`default_nettype none
module lep_dp (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire lep_pkg::t_cmd   i_cmd,
    input  wire logic [8:0]      i_a_index,
    input  wire logic [8:0]      i_b_index,
    input  wire logic [8:0]      i_c_index,
    input  wire logic [31:0]     i_a_low,
    input  wire logic [31:0]     i_a_step,
    input  wire logic [31:0]     i_b_low,
    input  wire logic [31:0]     i_b_step,
    input  wire logic [31:0]     i_c_low,
    input  wire logic [31:0]     i_c_step,
    output lep_pkg::t_stat       o_stat,
    output logic signed [31:0]   o_exponent,
    output logic                 o_log_of_zero,
    output logic                 o_left_interval,
    output logic                 o_valid
);

    localparam int SW = lep_pkg::SUM_W;
    localparam int DW = lep_pkg::DIV_W;

    logic [31:0]          r_rate [3];
    logic [31:0]          r_x;
    logic [31:0]          r_p;
    logic [63:0]          r_v;
    logic [5:0]           r_lz;
    logic [31:0]          r_y;
    logic [5:0]           r_e;
    logic [23:0]          r_f;
    logic [61:0]          r_prod;
    logic signed [SW-1:0] r_sum;
    logic                 r_zero;
    logic                 r_left;
    logic [SW-1:0]        r_quo;
    logic [DW-1:0]        r_rem;
    logic [DW-1:0]        r_div;
    logic                 r_neg;
    logic                 r_valid;

    logic [31:0]          rate;
    logic [63:0]          prod_p;
    logic [63:0]          prod_x;
    logic [34:0]          x_raw;
    logic [32:0]          x2;
    logic [31:0]          t_abs;
    logic [63:0]          sq;
    logic [62:0]          rounded;
    logic signed [31:0]   term;
    logic [DW:0]          rem2;
    logic [SW-1:0]        sum_mag;
    logic [63:0]          v_hi, v_lo;
    logic [5:0]           lz_hi, lz_lo;
    logic [31:0]          sat_q;

    // The product of step and index reaches 41 bits before saturation.
    function automatic logic [31:0] make_rate(input logic [31:0] low,
                                              input logic [31:0] step,
                                              input logic [8:0]  idx);
        logic [41:0] v;
        begin
            v = {10'd0, low} + ({10'd0, step} * {33'd0, idx});
            make_rate = (v[41:32] != 10'd0) ? 32'hFFFF_FFFF : v[31:0];
        end
    endfunction

    always_comb begin
        rate    = (i_cmd.sel[1]) ? r_rate[2] : r_rate[{1'b0, i_cmd.sel[0]}];
        prod_p  = {32'd0, r_x} * {32'd0, lep_pkg::ONE_Q31 - r_x};
        prod_x  = {32'd0, rate} * {32'd0, r_p};
        x_raw   = prod_x[63:29];
        x2      = {r_x, 1'b0};
        t_abs   = (x2 >= {1'b0, lep_pkg::ONE_Q31}) ?
                  32'(x2 - {1'b0, lep_pkg::ONE_Q31}) :
                  32'({1'b0, lep_pkg::ONE_Q31} - x2);
        sq      = {32'd0, r_y} * {32'd0, r_y};
        rounded = {1'b0, r_prod} + 63'(64'd1 << 31);
        term    = signed'(32'(rounded[62:32])) - signed'(lep_pkg::LOG_BIAS);
        rem2    = {r_rem, r_quo[SW-1]};
        sum_mag = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);

        // Two normalization passes of three shifts each.
        v_hi  = r_v;
        lz_hi = 6'd0;
        if (v_hi[63:32] == 32'd0) begin v_hi = v_hi << 32; lz_hi = lz_hi + 6'd32; end
        if (v_hi[63:48] == 16'd0) begin v_hi = v_hi << 16; lz_hi = lz_hi + 6'd16; end
        if (v_hi[63:56] == 8'd0)  begin v_hi = v_hi << 8;  lz_hi = lz_hi + 6'd8;  end
        v_lo  = r_v;
        lz_lo = r_lz;
        if (v_lo[63:60] == 4'd0)  begin v_lo = v_lo << 4;  lz_lo = lz_lo + 6'd4;  end
        if (v_lo[63:62] == 2'd0)  begin v_lo = v_lo << 2;  lz_lo = lz_lo + 6'd2;  end
        if (!v_lo[63])            begin v_lo = v_lo << 1;  lz_lo = lz_lo + 6'd1;  end

        if (r_neg) begin
            sat_q = (r_quo > SW'(64'h8000_0000)) ? 32'h8000_0000 : 32'(-r_quo);
        end else begin
            sat_q = (r_quo > SW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : r_quo[31:0];
        end
    end

    assign o_stat.m_zero = (r_v == 64'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.op == lep_pkg::OP_OUT);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            lep_pkg::OP_LOAD: begin
                r_rate[0] <= make_rate(i_a_low, i_a_step, i_a_index);
                r_rate[1] <= make_rate(i_b_low, i_b_step, i_b_index);
                r_rate[2] <= make_rate(i_c_low, i_c_step, i_c_index);
                r_x       <= lep_pkg::X_START;
                r_sum     <= '0;
                r_zero    <= 1'b0;
                r_left    <= 1'b0;
            end
            lep_pkg::OP_P: begin
                r_p <= prod_p[62:31];
            end
            lep_pkg::OP_X: begin
                if (x_raw > 35'(lep_pkg::ONE_Q31)) begin
                    r_x    <= lep_pkg::ONE_Q31;
                    r_left <= 1'b1;
                end else begin
                    r_x <= x_raw[31:0];
                end
            end
            lep_pkg::OP_M: begin
                r_v <= {32'd0, rate} * {32'd0, t_abs};
            end
            lep_pkg::OP_NORM_HI: begin
                if (r_v == 64'd0) begin
                    r_zero <= 1'b1;
                end
                r_v  <= v_hi;
                r_lz <= lz_hi;
            end
            lep_pkg::OP_NORM_LO: begin
                r_y <= v_lo[63:32];
                r_e <= 6'd63 - lz_lo;
                r_f <= 24'd0;
            end
            lep_pkg::OP_SQR: begin
                r_y <= sq[63] ? sq[63:32] : sq[62:31];
                r_f <= {r_f[22:0], sq[63]};
            end
            lep_pkg::OP_SCALE: begin
                r_prod <= 62'({34'd0, r_e, r_f} * {32'd0, lep_pkg::LN2_Q32});
            end
            lep_pkg::OP_ACC: begin
                r_sum <= r_sum + SW'(term);
            end
            lep_pkg::OP_DIV_INIT: begin
                r_quo <= sum_mag;
                r_neg <= r_sum[SW-1];
                r_rem <= '0;
                r_div <= DW'(lep_pkg::ROUNDS) * DW'(i_cmd.len);
            end
            lep_pkg::OP_DIV: begin
                if (rem2 >= {1'b0, r_div}) begin
                    r_rem <= DW'(rem2 - {1'b0, r_div});
                    r_quo <= {r_quo[SW-2:0], 1'b1};
                end else begin
                    r_rem <= rem2[DW-1:0];
                    r_quo <= {r_quo[SW-2:0], 1'b0};
                end
            end
            lep_pkg::OP_OUT: begin
                o_exponent      <= r_zero ? 32'sh8000_0000 : signed'(sat_q);
                o_log_of_zero   <= r_zero;
                o_left_interval <= r_left;
            end
            default: begin
            end
        endcase
    end

    assign o_valid = r_valid;

endmodule
`default_nettype wire

[rtl/core/lyapunov_exponent_point_core.sv]
// Top level of the Lyapunov exponent point core: configuration registers and wiring.
// Depends on lep_pkg, lep_ctrl and lep_dp.
`default_nettype none
// A point transaction is accepted when start is high while busy is low; busy stays
// high until the cycle in which the result is shown. Each point produces exactly one
// result, held on o_exponent, o_log_of_zero and o_left_interval for the single cycle
// in which o_valid is high; the receiver cannot stall it, so it must take the result
// then.
// A point runs the load step, ROUNDS passes over the L pattern steps, the divider
// setup, the SUM_W divider steps and the output step, where L is the clamped pattern
// length and SUM_W is 46. A map step with a zero derivative ends after normalization;
// otherwise the logarithm unit squares the mantissa once per fraction bit for 24 bits,
// then scales and accumulates. The final division is a restoring divider that retires
// one quotient bit a cycle. The default pattern length is five.
// Configuration registers must be written only while busy is low.
module lyapunov_exponent_point_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [8:0]         i_a_index,
    input  wire logic [8:0]         i_b_index,
    input  wire logic [8:0]         i_c_index,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    output logic signed [31:0]      o_exponent,
    output logic                    o_log_of_zero,
    output logic                    o_left_interval,
    output logic                    o_valid
);

    logic [31:0]     r_a_low, r_a_step, r_b_low, r_b_step, r_c_low, r_c_step;
    logic [31:0]     r_pattern;
    logic [4:0]      r_length;
    lep_pkg::t_cmd   cmd;
    lep_pkg::t_stat  stat;

    // Configuration registers; they reset to rate 3.0, step 1/512 and pattern ABABC.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_low   <= 32'd1610612736;
            r_a_step  <= 32'd1048576;
            r_b_low   <= 32'd1610612736;
            r_b_step  <= 32'd1048576;
            r_c_low   <= 32'd1610612736;
            r_c_step  <= 32'd1048576;
            r_pattern <= 32'd580;
            r_length  <= 5'd5;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lep_pkg::CFG_A_LOW:   r_a_low   <= i_cfg_data;
                lep_pkg::CFG_A_STEP:  r_a_step  <= i_cfg_data;
                lep_pkg::CFG_B_LOW:   r_b_low   <= i_cfg_data;
                lep_pkg::CFG_B_STEP:  r_b_step  <= i_cfg_data;
                lep_pkg::CFG_C_LOW:   r_c_low   <= i_cfg_data;
                lep_pkg::CFG_C_STEP:  r_c_step  <= i_cfg_data;
                lep_pkg::CFG_PATTERN: r_pattern <= i_cfg_data;
                lep_pkg::CFG_LENGTH:  r_length  <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // The sequencer walks rounds, pattern steps, log iterations and divider steps.
    lep_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_pattern (r_pattern),
        .i_length  (r_length),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_busy    (busy)
    );

    // The datapath holds the rates, the map state, the running sum and the result.
    lep_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_a_index       (i_a_index),
        .i_b_index       (i_b_index),
        .i_c_index       (i_c_index),
        .i_a_low         (r_a_low),
        .i_a_step        (r_a_step),
        .i_b_low         (r_b_low),
        .i_b_step        (r_b_step),
        .i_c_low         (r_c_low),
        .i_c_step        (r_c_step),
        .o_stat          (stat),
        .o_exponent      (o_exponent),
        .o_log_of_zero   (o_log_of_zero),
        .o_left_interval (o_left_interval),
        .o_valid         (o_valid)
    );

endmodule
`default_nettype wire
